### rtl/tcst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcst_pkg;

	localparam int TCST_NUM_CONNS = 256;

	localparam logic [1:0] OP_PACKET = 2'd0;
	localparam logic [1:0] OP_NEW    = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [3:0] ST_NO = 4'd0;
	localparam logic [3:0] ST_SS = 4'd1;
	localparam logic [3:0] ST_SR = 4'd2;
	localparam logic [3:0] ST_ES = 4'd3;
	localparam logic [3:0] ST_FW = 4'd4;
	localparam logic [3:0] ST_CW = 4'd5;
	localparam logic [3:0] ST_LA = 4'd6;
	localparam logic [3:0] ST_TW = 4'd7;
	localparam logic [3:0] ST_CL = 4'd8;
	localparam logic [3:0] ST_S2 = 4'd9;

	typedef enum logic [2:0] {
		CLS_SYN    = 3'd0,
		CLS_SYNACK = 3'd1,
		CLS_FIN    = 3'd2,
		CLS_ACK    = 3'd3,
		CLS_RST    = 3'd4,
		CLS_NONE   = 3'd5
	} flag_cls_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] conn_index;
		logic       direction;
		logic [3:0] tcp_flags;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  next_state;
		logic        state_changed;
		logic        timeout_valid;
		logic [13:0] timeout_seconds;
	} result_t;

	localparam logic [13:0] TIMEOUT_TBL [10] = '{
		14'd0, 14'd60, 14'd60, 14'd10800, 14'd120, 14'd60, 14'd30, 14'd120, 14'd10, 14'd60
	};

	localparam logic [3:0] NEXT_TBL [2][6][10] = '{
		'{
			'{ST_SS, ST_SS, ST_SR, ST_ES, ST_FW, ST_CW, ST_LA, ST_SS, ST_SS, ST_S2},
			'{ST_NO, ST_SS, ST_SR, ST_ES, ST_FW, ST_CW, ST_LA, ST_TW, ST_CL, ST_SR},
			'{ST_NO, ST_SS, ST_FW, ST_FW, ST_LA, ST_LA, ST_LA, ST_TW, ST_CL, ST_S2},
			'{ST_ES, ST_S2, ST_ES, ST_ES, ST_CW, ST_CW, ST_TW, ST_TW, ST_CL, ST_S2},
			'{ST_NO, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL},
			'{ST_NO, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL}
		},
		'{
			'{ST_NO, ST_S2, ST_SR, ST_ES, ST_FW, ST_CW, ST_LA, ST_TW, ST_CL, ST_S2},
			'{ST_NO, ST_SR, ST_SR, ST_ES, ST_FW, ST_CW, ST_LA, ST_TW, ST_CL, ST_SR},
			'{ST_NO, ST_SS, ST_FW, ST_FW, ST_LA, ST_LA, ST_LA, ST_TW, ST_CL, ST_S2},
			'{ST_NO, ST_SS, ST_SR, ST_ES, ST_CW, ST_CW, ST_TW, ST_TW, ST_CL, ST_S2},
			'{ST_NO, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL},
			'{ST_NO, ST_SS, ST_SR, ST_ES, ST_FW, ST_CW, ST_LA, ST_TW, ST_CL, ST_S2}
		}
	};

endpackage

`default_nettype wire

### rtl/tcst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcst_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/tcst_next.sv
`timescale 1ns / 1ps
`default_nettype none

module tcst_next
	import tcst_pkg::*;
(
	input  wire logic [1:0] operation,
	input  wire logic       direction,
	input  wire logic [3:0] tcp_flags,
	input  wire logic [3:0] old_state,
	output result_t         res
);

	flag_cls_t  cls;
	logic [3:0] cur;
	logic [3:0] now;

	always_comb begin
		priority if (tcp_flags[2]) begin
			cls = CLS_RST;
		end else if (tcp_flags[1]) begin
			cls = tcp_flags[3] ? CLS_SYNACK : CLS_SYN;
		end else if (tcp_flags[0]) begin
			cls = CLS_FIN;
		end else if (tcp_flags[3]) begin
			cls = CLS_ACK;
		end else begin
			cls = CLS_NONE;
		end
	end

	// Codes above the last state are looked up as CLOSE.
	assign cur = (old_state > ST_S2) ? ST_CL : old_state;

	always_comb begin
		res = '0;
		now = old_state;
		unique case (operation)
			OP_PACKET: begin
				now = NEXT_TBL[direction][cls][cur];
				res.timeout_valid = 1'b1;
				res.timeout_seconds = TIMEOUT_TBL[now];
			end
			OP_NEW: begin
				if (old_state == ST_NO) begin
					now = ST_SS;
				end
			end
			OP_CLEAR: begin
				now = ST_NO;
			end
			default: begin
				now = old_state;
			end
		endcase
		res.next_state = now;
		res.state_changed = (now != old_state);
	end

endmodule

`default_nettype wire

### rtl/tcp_conn_state_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Tracks the TCP state of NUM_CONNS connections and takes one item per clock
// cycle whenever busy is low. The result of an item is driven for one cycle,
// marked by result_valid, from the s2 result register that follows the s1
// item register and the registered RAM read; the receiver cannot hold it off.
// The state store is a single-port-write RAM with a registered read, and
// back-to-back items to the same connection are served by forwarding the
// last written state. After reset the block holds busy high while it writes
// NONE to every entry.
module tcp_conn_state_tracker
	import tcst_pkg::*;
#(
	parameter int NUM_CONNS = TCST_NUM_CONNS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire in_item_t item,
	output logic          result_valid,
	output result_t       result
);

	localparam int AW = (NUM_CONNS > 1) ? $clog2(NUM_CONNS) : 1;
	localparam int CW = ((AW > 8) ? AW : 8) + 1;

	logic          accept;
	logic          in_range;
	logic          valid_s1;
	in_item_t      item_s1;
	logic          inrange_s1;
	logic          fwd_s1;
	logic [3:0]    fwd_state_s1;
	logic          result_valid_s2;
	result_t       result_s2;
	logic          clr_active_q;
	logic [AW-1:0] clr_cnt_q;
	logic [3:0]    ram_rdata;
	logic [3:0]    old_state;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [3:0]    ram_wdata;
	result_t       next_res;

	assign busy = clr_active_q;
	assign accept = start && !busy;
	assign in_range = CW'(item.conn_index) < CW'(NUM_CONNS);

	assign ram_we = clr_active_q || (valid_s1 && inrange_s1);
	assign ram_waddr = clr_active_q ? clr_cnt_q : AW'(item_s1.conn_index);
	assign ram_wdata = clr_active_q ? ST_NO : next_res.next_state;

	tcst_ram #(
		.WIDTH(4),
		.DEPTH(NUM_CONNS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(AW'(item.conn_index)),
		.rdata(ram_rdata)
	);

	assign old_state = fwd_s1 ? fwd_state_s1 : ram_rdata;

	tcst_next u_next (
		.operation(item_s1.operation),
		.direction(item_s1.direction),
		.tcp_flags(item_s1.tcp_flags),
		.old_state(old_state),
		.res      (next_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			result_valid_s2 <= 1'b0;
			clr_active_q <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			valid_s1 <= accept;
			result_valid_s2 <= valid_s1;
			if (clr_active_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == AW'(NUM_CONNS - 1)) begin
					clr_active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			inrange_s1 <= in_range;
			fwd_s1 <= valid_s1 && inrange_s1 && (item.conn_index == item_s1.conn_index);
			fwd_state_s1 <= next_res.next_state;
		end
		if (valid_s1) begin
			result_s2 <= inrange_s1 ? next_res : '0;
		end
	end

	assign result_valid = result_valid_s2;
	assign result = result_s2;

	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !result_valid)
		else $error("result delivered during the clearing pass");

	a_result_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 result_valid)
		else $error("accepted item gave no result");

	a_state_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.next_state <= ST_S2))
		else $error("result state code out of range");

	a_timeout_only_for_packets: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.timeout_valid) |-> (result.timeout_seconds == 14'd0))
		else $error("timeout reported without timeout_valid");

endmodule

`default_nettype wire

### tb/tb_tcp_conn_state_tracker.sv
`timescale 1ns / 1ps

module tb_tcp_conn_state_tracker;
	import tcst_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic DIR_ORIG  = 1'b0;
	localparam logic DIR_REPLY = 1'b1;

	localparam logic [3:0] F_NONE = 4'b0000;
	localparam logic [3:0] F_FIN  = 4'b0001;
	localparam logic [3:0] F_SYN  = 4'b0010;
	localparam logic [3:0] F_RST  = 4'b0100;
	localparam logic [3:0] F_ACK  = 4'b1000;

	localparam int CYCLE_LIMIT = 200000;

	class conn_scoreboard;
		logic [3:0] conn_state [TCST_NUM_CONNS];
		result_t expected_q [$];
		int mismatches;

		logic [13:0] timeout_tbl [10] = '{
			14'd0, 14'd60, 14'd60, 14'd10800, 14'd120, 14'd60, 14'd30, 14'd120, 14'd10, 14'd60
		};

		logic [3:0] next_tbl [2][6][10] = '{
			'{
				'{ST_SS, ST_SS, ST_SR, ST_ES, ST_FW, ST_CW, ST_LA, ST_SS, ST_SS, ST_S2},
				'{ST_NO, ST_SS, ST_SR, ST_ES, ST_FW, ST_CW, ST_LA, ST_TW, ST_CL, ST_SR},
				'{ST_NO, ST_SS, ST_FW, ST_FW, ST_LA, ST_LA, ST_LA, ST_TW, ST_CL, ST_S2},
				'{ST_ES, ST_S2, ST_ES, ST_ES, ST_CW, ST_CW, ST_TW, ST_TW, ST_CL, ST_S2},
				'{ST_NO, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL},
				'{ST_NO, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL}
			},
			'{
				'{ST_NO, ST_S2, ST_SR, ST_ES, ST_FW, ST_CW, ST_LA, ST_TW, ST_CL, ST_S2},
				'{ST_NO, ST_SR, ST_SR, ST_ES, ST_FW, ST_CW, ST_LA, ST_TW, ST_CL, ST_SR},
				'{ST_NO, ST_SS, ST_FW, ST_FW, ST_LA, ST_LA, ST_LA, ST_TW, ST_CL, ST_S2},
				'{ST_NO, ST_SS, ST_SR, ST_ES, ST_CW, ST_CW, ST_TW, ST_TW, ST_CL, ST_S2},
				'{ST_NO, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL, ST_CL},
				'{ST_NO, ST_SS, ST_SR, ST_ES, ST_FW, ST_CW, ST_LA, ST_TW, ST_CL, ST_S2}
			}
		};

		function new();
			foreach (conn_state[i])
				conn_state[i] = ST_NO;
			mismatches = 0;
		endfunction

		function flag_cls_t classify(logic [3:0] flags);
			if ((flags & F_RST) != 0)
				return CLS_RST;
			if ((flags & F_SYN) != 0)
				return ((flags & F_ACK) != 0) ? CLS_SYNACK : CLS_SYN;
			if ((flags & F_FIN) != 0)
				return CLS_FIN;
			if ((flags & F_ACK) != 0)
				return CLS_ACK;
			return CLS_NONE;
		endfunction

		function void note(in_item_t it);
			result_t r;
			logic [3:0] prior;
			logic [3:0] cur;
			r = '0;
			if (int'(it.conn_index) < TCST_NUM_CONNS) begin
				prior = conn_state[it.conn_index];
				r.next_state = prior;
				case (it.operation)
					OP_PACKET: begin
						// Codes above the last state are looked up as CLOSE.
						cur = (prior > ST_S2) ? ST_CL : prior;
						r.next_state = next_tbl[it.direction][classify(it.tcp_flags)][cur];
						r.timeout_valid = 1'b1;
						r.timeout_seconds = timeout_tbl[r.next_state];
					end
					OP_NEW: begin
						if (prior == ST_NO)
							r.next_state = ST_SS;
					end
					OP_CLEAR: begin
						r.next_state = ST_NO;
					end
					default: begin
					end
				endcase
				r.state_changed = (r.next_state != prior);
				conn_state[it.conn_index] = r.next_state;
			end
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing expected, next_state %0d",
					got.next_state));
			end else begin
				want = expected_q.pop_front();
				if (got.next_state !== want.next_state)
					report($sformatf("next_state %0d, expected %0d", got.next_state,
						want.next_state));
				if (got.state_changed !== want.state_changed)
					report($sformatf("state_changed %0b, expected %0b", got.state_changed,
						want.state_changed));
				if (got.timeout_valid !== want.timeout_valid)
					report($sformatf("timeout_valid %0b, expected %0b", got.timeout_valid,
						want.timeout_valid));
				if (got.timeout_seconds !== want.timeout_seconds)
					report($sformatf("timeout_seconds %0d, expected %0d",
						got.timeout_seconds, want.timeout_seconds));
			end
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic result_valid;
	result_t result;

	conn_scoreboard sb = new();
	int sender_idle_pct;
	int items_sent;
	int cycle_count;

	tcp_conn_state_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (result_valid === 1'b1)
			sb.check(result);
		if (start === 1'b1 && busy === 1'b0)
			sb.note(item);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tcp_conn_state_tracker: mismatch");
			$finish;
		end
	end

	function automatic in_item_t mk(logic [1:0] op, logic [7:0] idx, logic dir,
		logic [3:0] flags);
		in_item_t it;
		it.operation = op;
		it.conn_index = idx;
		it.direction = dir;
		it.tcp_flags = flags;
		return it;
	endfunction

	// Called at a rising edge; returns at the edge that accepted the item.
	task send(in_item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		items_sent++;
	endtask

	task send_noise();
		logic [1:0] op;
		case ($urandom_range(9))
			0: op = OP_NEW;
			1: op = OP_CLEAR;
			2: op = OP_UNUSED;
			default: op = OP_PACKET;
		endcase
		send(mk(op, 8'($urandom_range(255)), 1'($urandom_range(1)),
			4'($urandom_range(15))));
	endtask

	// A handshake, some data and a teardown on one connection, sometimes cut
	// short and with a few items carrying random flags.
	task run_session(logic [7:0] idx);
		in_item_t seq [$];
		in_item_t it;
		int keep;
		if ($urandom_range(1) == 1)
			seq.push_back(mk(OP_CLEAR, idx, DIR_ORIG, F_NONE));
		if ($urandom_range(1) == 1)
			seq.push_back(mk(OP_NEW, idx, DIR_ORIG, F_NONE));
		seq.push_back(mk(OP_PACKET, idx, DIR_ORIG, F_SYN));
		seq.push_back(mk(OP_PACKET, idx, DIR_REPLY, F_SYN | F_ACK));
		seq.push_back(mk(OP_PACKET, idx, DIR_ORIG, F_ACK));
		repeat ($urandom_range(4))
			seq.push_back(mk(OP_PACKET, idx, 1'($urandom_range(1)), F_ACK));
		if ($urandom_range(1) == 1) begin
			seq.push_back(mk(OP_PACKET, idx, DIR_ORIG, F_FIN | F_ACK));
			seq.push_back(mk(OP_PACKET, idx, DIR_REPLY, F_ACK));
			seq.push_back(mk(OP_PACKET, idx, DIR_REPLY, F_FIN | F_ACK));
			seq.push_back(mk(OP_PACKET, idx, DIR_ORIG, F_ACK));
		end else begin
			seq.push_back(mk(OP_PACKET, idx, DIR_REPLY, F_FIN | F_ACK));
			seq.push_back(mk(OP_PACKET, idx, DIR_ORIG, F_ACK));
			seq.push_back(mk(OP_PACKET, idx, DIR_ORIG, F_FIN | F_ACK));
			seq.push_back(mk(OP_PACKET, idx, DIR_REPLY, F_ACK));
		end
		keep = ($urandom_range(3) == 0) ? $urandom_range(seq.size()) : seq.size();
		foreach (seq[i]) begin
			if (i < keep) begin
				it = seq[i];
				if ($urandom_range(9) == 0)
					it.tcp_flags = 4'($urandom_range(15));
				send(it);
			end
		end
	endtask

	task random_phase(int count);
		int goal;
		goal = items_sent + count;
		while (items_sent < goal) begin
			if ($urandom_range(9) < 7)
				run_session(($urandom_range(3) == 0) ? 8'($urandom_range(255))
					: 8'($urandom_range(15) * 17));
			else
				send_noise();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		items_sent = 0;
		cycle_count = 0;
		sender_idle_pct = 7;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send(mk(OP_PACKET, 8'd0, DIR_ORIG, F_NONE));
		send(mk(OP_NEW, 8'd255, DIR_ORIG, F_NONE));
		send(mk(OP_NEW, 8'd255, DIR_REPLY, F_NONE));
		send(mk(OP_UNUSED, 8'd255, DIR_ORIG, F_NONE));
		send(mk(OP_PACKET, 8'd255, DIR_REPLY, F_FIN | F_SYN | F_RST | F_ACK));
		send(mk(OP_PACKET, 8'd255, DIR_ORIG, F_SYN));
		send(mk(OP_PACKET, 8'd255, DIR_REPLY, F_SYN | F_ACK));
		send(mk(OP_PACKET, 8'd255, DIR_ORIG, F_ACK));
		send(mk(OP_PACKET, 8'd255, DIR_ORIG, F_FIN));
		send(mk(OP_PACKET, 8'd255, DIR_REPLY, F_ACK));
		send(mk(OP_PACKET, 8'd255, DIR_REPLY, F_FIN));
		send(mk(OP_PACKET, 8'd255, DIR_ORIG, F_ACK));
		send(mk(OP_PACKET, 8'd255, DIR_ORIG, F_SYN));
		send(mk(OP_PACKET, 8'd255, DIR_REPLY, F_SYN));
		send(mk(OP_PACKET, 8'd255, DIR_ORIG, F_RST));
		send(mk(OP_CLEAR, 8'd255, DIR_ORIG, F_NONE));
		send(mk(OP_CLEAR, 8'd255, DIR_ORIG, F_NONE));
		send(mk(OP_UNUSED, 8'd0, DIR_REPLY, F_FIN | F_SYN | F_RST | F_ACK));
		send(mk(OP_PACKET, 8'd0, DIR_REPLY, F_NONE));
		send(mk(OP_PACKET, 8'd128, DIR_ORIG, F_ACK));
		send(mk(OP_PACKET, 8'd128, DIR_REPLY, F_FIN | F_ACK));
		send(mk(OP_PACKET, 8'd128, DIR_ORIG, F_SYN | F_FIN));
		send(mk(OP_PACKET, 8'd1, DIR_REPLY, F_SYN | F_ACK));

		random_phase(200);
		sender_idle_pct = 69;
		random_phase(200);
		sender_idle_pct = 0;
		random_phase(200);
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tcp_conn_state_tracker: match");
		else
			$display("tcp_conn_state_tracker: mismatch");
		$finish;
	end

endmodule
